[hdl/dmsp_pkg.sv]
// ----------------------------------------------------------------------------
// dmsp_pkg
// Shared types, constants and reset values for the dual motor sync position
// loop: phase and command kind codes, the per-item control record and the
// configuration register set.
// ----------------------------------------------------------------------------
package dmsp_pkg;

   // default encoder count width
   localparam int POSITION_BITS_DEFAULT = 16;

   // fixed field widths
   localparam int TARGET_BITS    = 16;
   localparam int GAIN_BITS      = 24;
   localparam int SPEED_BITS     = 15;
   localparam int WINDOW_BITS    = 8;
   localparam int OUT_BITS       = 16;
   localparam int FRAC_BITS      = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   // front to back queue depth
   localparam int QUEUE_DEPTH = 4;

   // configuration reset values
   localparam logic [TARGET_BITS-1:0] TARGET_RESET = 16'd0;
   localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 24'd1073742;
   localparam logic [SPEED_BITS-1:0]  MIN_RESET    = 15'd1966;
   localparam logic [SPEED_BITS-1:0]  MAX_RESET    = 15'd26214;
   localparam logic [SPEED_BITS-1:0]  CREEP_RESET  = 15'd1638;
   localparam logic [WINDOW_BITS-1:0] COARSE_RESET = 8'd9;
   localparam logic [WINDOW_BITS-1:0] FINE_RESET   = 8'd6;
   localparam logic [WINDOW_BITS-1:0] SYNC_RESET   = 8'd10;

   // move phase codes
   typedef enum logic [1:0] {
      PHASE_COARSE = 2'd0,
      PHASE_FINE   = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

   // what the back end does with one item
   typedef enum logic [1:0] {
      KIND_HOLD   = 2'd0,   // zero speeds, command valid
      KIND_TIE    = 2'd1,   // zero speeds, command not valid
      KIND_CREEP  = 2'd2,   // fixed creep speed toward target
      KIND_COARSE = 2'd3    // proportional speed with limits
   } kind_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TARGET = 3'd0,
      CSR_GAIN   = 3'd1,
      CSR_MIN    = 3'd2,
      CSR_MAX    = 3'd3,
      CSR_CREEP  = 3'd4,
      CSR_COARSE = 3'd5,
      CSR_FINE   = 3'd6,
      CSR_SYNC   = 3'd7
   } csr_index_type;

   // classified item handed from front to back
   typedef struct packed {
      kind_type  kind;
      logic      halve1;
      logic      halve2;
      logic      neg1;
      logic      neg2;
      logic      nz1;
      logic      nz2;
      phase_type phase;
   } ctl_type;

   // configuration register set
   typedef struct packed {
      logic [TARGET_BITS-1:0] target;
      logic [GAIN_BITS-1:0]   gain;
      logic [SPEED_BITS-1:0]  min_speed;
      logic [SPEED_BITS-1:0]  max_speed;
      logic [SPEED_BITS-1:0]  creep_speed;
      logic [WINDOW_BITS-1:0] coarse_window;
      logic [WINDOW_BITS-1:0] fine_window;
      logic [WINDOW_BITS-1:0] sync_window;
   } cfg_type;

endpackage

[hdl/dmsp_front.sv]
// ----------------------------------------------------------------------------
// dmsp_front
// Front end: computes both position errors, runs the phase machine and
// classifies each accepted beat into a command kind for the back end.
// ----------------------------------------------------------------------------
module dmsp_front
   import dmsp_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     accept,
   input  logic [POSITION_BITS-1:0] first_position,
   input  logic [POSITION_BITS-1:0] second_position,
   input  logic                     restart,
   output ctl_type                  ctl,
   output logic [POSITION_BITS:0]   mag1,
   output logic [POSITION_BITS:0]   mag2
);

   localparam int MAG_BITS = POSITION_BITS + 1;

   phase_type              phase_ff;
   phase_type              phase_in;
   phase_type              phase_eff;
   logic [POSITION_BITS-1:0] tgt;
   logic [MAG_BITS-1:0]    err1;
   logic [MAG_BITS-1:0]    err2;
   logic [MAG_BITS-1:0]    diff;
   logic [MAG_BITS-1:0]    diff_mag;
   logic                   in_coarse;
   logic                   in_fine;
   logic                   in_sync;

   // target taken at position width, then sign extended
   assign tgt = POSITION_BITS'(cfg.target);

   // exact errors and motor difference, one bit wider than a position
   assign err1 = {tgt[POSITION_BITS-1], tgt}
               - {first_position[POSITION_BITS-1], first_position};
   assign err2 = {tgt[POSITION_BITS-1], tgt}
               - {second_position[POSITION_BITS-1], second_position};
   assign diff = {first_position[POSITION_BITS-1], first_position}
               - {second_position[POSITION_BITS-1], second_position};

   // magnitudes
   assign mag1     = err1[MAG_BITS-1] ? -err1 : err1;
   assign mag2     = err2[MAG_BITS-1] ? -err2 : err2;
   assign diff_mag = diff[MAG_BITS-1] ? -diff : diff;

   // window checks
   assign in_coarse = (mag1 <= MAG_BITS'(cfg.coarse_window))
                   && (mag2 <= MAG_BITS'(cfg.coarse_window));
   assign in_fine   = (mag1 <= MAG_BITS'(cfg.fine_window))
                   && (mag2 <= MAG_BITS'(cfg.fine_window));
   assign in_sync   = diff_mag <= MAG_BITS'(cfg.sync_window);

   assign phase_eff = restart ? PHASE_COARSE : phase_ff;

   // classify and pick next phase
   always_comb begin
      ctl.kind   = KIND_HOLD;
      ctl.halve1 = 1'b0;
      ctl.halve2 = 1'b0;
      ctl.neg1   = err1[MAG_BITS-1];
      ctl.neg2   = err2[MAG_BITS-1];
      ctl.nz1    = mag1 != '0;
      ctl.nz2    = mag2 != '0;
      phase_in   = PHASE_DONE;
      case (phase_eff)
         PHASE_COARSE: begin
            if (in_coarse) begin
               phase_in = PHASE_FINE;
            end else begin
               phase_in = PHASE_COARSE;
               ctl.kind = KIND_COARSE;
               if (!in_sync) begin
                  if (mag1 > mag2) begin
                     ctl.halve2 = 1'b1;
                  end else if (mag2 > mag1) begin
                     ctl.halve1 = 1'b1;
                  end else begin
                     ctl.kind = KIND_TIE;
                  end
               end
            end
         end
         PHASE_FINE: begin
            if (in_fine) begin
               phase_in = PHASE_DONE;
            end else begin
               phase_in = PHASE_FINE;
               ctl.kind = KIND_CREEP;
            end
         end
         default: begin
            phase_in = PHASE_DONE;
         end
      endcase
      ctl.phase = phase_in;
   end

   // phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_DONE;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

endmodule

[hdl/dmsp_queue.sv]
// ----------------------------------------------------------------------------
// dmsp_queue
// Small first-in first-out queue between the front and back ends so that
// either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module dmsp_queue
   import dmsp_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             not_full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   assign not_full  = count_ff != COUNT_BITS'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // fill count stays in range
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(DEPTH))
      else $error("queue fill count above depth");

   // no push into a full queue, no pop from an empty one
   assert property (@(posedge clock) disable iff (reset)
      !(push && !not_full) && !(pop && !not_empty))
      else $error("queue overflow or underflow");

   // a push with no pop grows the fill count by one
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill count lost a push");

endmodule

[hdl/dmsp_back.sv]
// ----------------------------------------------------------------------------
// dmsp_back
// Back end: multiplies each error by the gain, then applies the speed limits,
// the sync halving and the sign, and holds the result beat until taken.
// ----------------------------------------------------------------------------
module dmsp_back
   import dmsp_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     q_valid,
   input  ctl_type                  q_ctl,
   input  logic [POSITION_BITS:0]   q_mag1,
   input  logic [POSITION_BITS:0]   q_mag2,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [OUT_BITS-1:0]      rsp_first_speed,
   output logic [OUT_BITS-1:0]      rsp_second_speed,
   output logic                     rsp_command_valid,
   output logic [1:0]               rsp_move_phase
);

   localparam int MAG_BITS  = POSITION_BITS + 1;
   localparam int PROD_BITS = MAG_BITS + GAIN_BITS;
   localparam int HIGH_BITS = PROD_BITS - FRAC_BITS;

   // product stage
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   ctl_type               s1_ctl_ff;
   logic [PROD_BITS-1:0]  s1_prod1_ff;
   logic [PROD_BITS-1:0]  s1_prod2_ff;

   // output stage
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [OUT_BITS-1:0]   speed1_ff;
   logic [OUT_BITS-1:0]   speed1_in;
   logic [OUT_BITS-1:0]   speed2_ff;
   logic [OUT_BITS-1:0]   speed2_in;
   logic                  cmd_valid_ff;
   logic                  cmd_valid_in;
   phase_type             phase_ff;

   logic                  out_load;
   logic [SPEED_BITS-1:0] m1;
   logic [SPEED_BITS-1:0] m2;

   // limited magnitude of one scaled error
   function automatic logic [SPEED_BITS-1:0] limit_mag(
      input logic [PROD_BITS-1:0]  prod,
      input logic [SPEED_BITS-1:0] lo,
      input logic [SPEED_BITS-1:0] hi
   );
      logic [HIGH_BITS-1:0]  whole;
      logic [SPEED_BITS-1:0] res;
      whole = prod[PROD_BITS-1:FRAC_BITS];
      if (whole >= HIGH_BITS'(hi)) begin
         res = hi;
      end else if (prod != '0 && whole <= HIGH_BITS'(lo)) begin
         res = lo;
      end else begin
         res = whole[SPEED_BITS-1:0];
      end
      return res;
   endfunction

   // apply direction of the error
   function automatic logic [OUT_BITS-1:0] signed_speed(
      input logic                  neg,
      input logic [SPEED_BITS-1:0] mag
   );
      logic [OUT_BITS-1:0] wide;
      wide = {1'b0, mag};
      return neg ? -wide : wide;
   endfunction

   // pipeline advance
   assign out_load    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign q_pop       = q_valid && (!s1_valid_ff || out_load);
   assign s1_valid_in = q_pop || (s1_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // gain products
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_ctl_ff   <= q_ctl;
         s1_prod1_ff <= PROD_BITS'(q_mag1) * PROD_BITS'(cfg.gain);
         s1_prod2_ff <= PROD_BITS'(q_mag2) * PROD_BITS'(cfg.gain);
      end
   end

   // speed limits and sync halving
   always_comb begin
      m1 = limit_mag(s1_prod1_ff, cfg.min_speed, cfg.max_speed);
      m2 = limit_mag(s1_prod2_ff, cfg.min_speed, cfg.max_speed);
      if (s1_ctl_ff.halve1) begin
         m1 = m1 >> 1;
      end
      if (s1_ctl_ff.halve2) begin
         m2 = m2 >> 1;
      end
   end

   // result composition per kind
   always_comb begin
      speed1_in    = '0;
      speed2_in    = '0;
      cmd_valid_in = 1'b1;
      case (s1_ctl_ff.kind)
         KIND_COARSE: begin
            speed1_in = signed_speed(s1_ctl_ff.neg1, m1);
            speed2_in = signed_speed(s1_ctl_ff.neg2, m2);
         end
         KIND_CREEP: begin
            speed1_in = s1_ctl_ff.nz1 ? signed_speed(s1_ctl_ff.neg1, cfg.creep_speed) : '0;
            speed2_in = s1_ctl_ff.nz2 ? signed_speed(s1_ctl_ff.neg2, cfg.creep_speed) : '0;
         end
         KIND_TIE: begin
            cmd_valid_in = 1'b0;
         end
         default: begin
            cmd_valid_in = 1'b1;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         speed1_ff    <= speed1_in;
         speed2_ff    <= speed2_in;
         cmd_valid_ff <= cmd_valid_in;
         phase_ff     <= s1_ctl_ff.phase;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_first_speed   = speed1_ff;
   assign rsp_second_speed  = speed2_ff;
   assign rsp_command_valid = cmd_valid_ff;
   assign rsp_move_phase    = phase_ff;

   // a tie beat carries zero speeds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_command_valid |-> rsp_first_speed == '0 && rsp_second_speed == '0)
      else $error("tie beat with nonzero speed");

   // a done beat commands standstill
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_move_phase == PHASE_DONE
         |-> rsp_command_valid && rsp_first_speed == '0 && rsp_second_speed == '0)
      else $error("done beat without standstill command");

   // a stalled result beat is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> !$past(out_load))
      else $error("result overwritten while stalled");

endmodule

[hdl/dual_motor_sync_position_loop_core.sv]
// ----------------------------------------------------------------------------
// dual_motor_sync_position_loop_core
// Synchronized position loop for two motors on one gantry axis: coarse
// proportional phase with limits and sync halving, then a fine creep phase.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The block takes a new encoder beat every
// cycle while req_ready is high. Each beat passes three registers on its way
// to the rsp_ side: the queue entry written at acceptance, the gain multiply,
// then limiting into the result register, where the result beat is held
// until rsp_ready takes it. Under a result stall the
// block holds six beats in flight before req_ready drops: four in the queue
// between the classifier and the multiply stage, one in the multiply stage and
// one in the result register. The phase register is updated when a beat is
// accepted, so consecutive beats see each other's phase with no gap.
// Configuration writes are taken every cycle on the csr_ port and should be
// made while no beat is in flight.
module dual_motor_sync_position_loop_core
   import dmsp_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [POSITION_BITS-1:0]  req_first_position,
   input  logic [POSITION_BITS-1:0]  req_second_position,
   input  logic                      req_restart,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [OUT_BITS-1:0]       rsp_first_speed,
   output logic [OUT_BITS-1:0]       rsp_second_speed,
   output logic                      rsp_command_valid,
   output logic [1:0]                rsp_move_phase,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int MAG_BITS   = POSITION_BITS + 1;
   localparam int CTL_BITS   = $bits(ctl_type);
   localparam int ENTRY_BITS = CTL_BITS + 2 * MAG_BITS;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic                  accept;
   ctl_type               front_ctl;
   logic [MAG_BITS-1:0]   front_mag1;
   logic [MAG_BITS-1:0]   front_mag2;
   logic [ENTRY_BITS-1:0] push_data;
   logic [ENTRY_BITS-1:0] pop_data;
   logic                  q_not_empty;
   logic                  q_pop;
   ctl_type               q_ctl;
   logic [MAG_BITS-1:0]   q_mag1;
   logic [MAG_BITS-1:0]   q_mag2;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TARGET: cfg_in.target        = csr_data[TARGET_BITS-1:0];
            CSR_GAIN:   cfg_in.gain          = csr_data[GAIN_BITS-1:0];
            CSR_MIN:    cfg_in.min_speed     = csr_data[SPEED_BITS-1:0];
            CSR_MAX:    cfg_in.max_speed     = csr_data[SPEED_BITS-1:0];
            CSR_CREEP:  cfg_in.creep_speed   = csr_data[SPEED_BITS-1:0];
            CSR_COARSE: cfg_in.coarse_window = csr_data[WINDOW_BITS-1:0];
            CSR_FINE:   cfg_in.fine_window   = csr_data[WINDOW_BITS-1:0];
            CSR_SYNC:   cfg_in.sync_window   = csr_data[WINDOW_BITS-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target        <= TARGET_RESET;
         cfg_ff.gain          <= GAIN_RESET;
         cfg_ff.min_speed     <= MIN_RESET;
         cfg_ff.max_speed     <= MAX_RESET;
         cfg_ff.creep_speed   <= CREEP_RESET;
         cfg_ff.coarse_window <= COARSE_RESET;
         cfg_ff.fine_window   <= FINE_RESET;
         cfg_ff.sync_window   <= SYNC_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end
   assign accept = req_valid && req_ready;

   dmsp_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .accept          (accept),
      .first_position  (req_first_position),
      .second_position (req_second_position),
      .restart         (req_restart),
      .ctl             (front_ctl),
      .mag1            (front_mag1),
      .mag2            (front_mag2)
   );

   // queue between front and back
   assign push_data = {front_ctl, front_mag1, front_mag2};

   dmsp_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (push_data),
      .not_full  (req_ready),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .not_empty (q_not_empty)
   );

   assign q_ctl  = ctl_type'(pop_data[ENTRY_BITS-1 -: CTL_BITS]);
   assign q_mag1 = pop_data[2*MAG_BITS-1 -: MAG_BITS];
   assign q_mag2 = pop_data[MAG_BITS-1:0];

   // back end
   dmsp_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (q_not_empty),
      .q_ctl             (q_ctl),
      .q_mag1            (q_mag1),
      .q_mag2            (q_mag2),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_first_speed   (rsp_first_speed),
      .rsp_second_speed  (rsp_second_speed),
      .rsp_command_valid (rsp_command_valid),
      .rsp_move_phase    (rsp_move_phase)
   );

endmodule
